@@ src/ifpr_pkg.sv @@
// ----------------------------------------------------------------------------
// ifpr_pkg: shared types and constants of the IMU frame parser ring
// Frame layout, ring geometry, result codes and address helpers.
// ----------------------------------------------------------------------------
package ifpr_pkg;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned REC_WORDS  = 17;
  localparam int unsigned SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned ADDR_W     = $clog2(RING_DEPTH * REC_WORDS);
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned ASM_W      = 24;

  localparam logic [7:0] HDR_BYTE = 8'h7E;
  localparam logic [7:0] HDR_KIND = 8'h0C;

  localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(70);
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(70 - 2);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(70 - 1);
  localparam logic [POS_W-1:0] TEMP_POS  = POS_W'(3);
  localparam logic [POS_W-1:0] TS_POS    = POS_W'(4);

  localparam logic [IDX_W-1:0] WORD_TEMP = IDX_W'(15);
  localparam logic [IDX_W-1:0] WORD_TS   = IDX_W'(16);
  localparam logic [IDX_W-1:0] WORD_LAST = IDX_W'(REC_WORDS - 1);

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_STORED = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_ISSUE,
    RD_WAIT
  } rd_state_e;

  // Word write toward the record store, slot-relative.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      data;
  } wr_req_t;

  // Frame completion event.
  typedef struct packed {
    logic valid;
    logic ok;
  } commit_t;

  // Frame float word order: accel Y,X,Z then gyro Y,X,Z, rest in place.
  function automatic logic [IDX_W-1:0] float_to_index(input logic [3:0] g);
    logic [IDX_W-1:0] r;
    case (g)
      4'd0:    r = IDX_W'(4);
      4'd1:    r = IDX_W'(3);
      4'd2:    r = IDX_W'(5);
      4'd3:    r = IDX_W'(1);
      4'd4:    r = IDX_W'(0);
      4'd5:    r = IDX_W'(2);
      default: r = IDX_W'(g);
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rec_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [IDX_W-1:0]  idx);
    return ADDR_W'(slot) * ADDR_W'(REC_WORDS) + ADDR_W'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

@@ src/ifpr_if.sv @@
// ----------------------------------------------------------------------------
// ifpr_if: request and result channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface ifpr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ifpr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  word_index;
  logic [31:0] word_value;
  logic        checksum_ok;
  logic        last;

  modport source (output valid, output kind, output word_index, output word_value,
                  output checksum_ok, output last, input ready);
  modport sink   (input valid, input kind, input word_index, input word_value,
                  input checksum_ok, input last, output ready);
endinterface

@@ src/ifpr_ram.sv @@
// ----------------------------------------------------------------------------
// ifpr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ifpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 272
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ifpr_parser.sv @@
// ----------------------------------------------------------------------------
// ifpr_parser: header hunt and frame byte parser
// Assembles record words, tracks the XOR check, flags frame completion.
// ----------------------------------------------------------------------------
module ifpr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output ifpr_pkg::wr_req_t wr_o,
  output ifpr_pkg::commit_t commit_o
);
  import ifpr_pkg::*;

  logic [15:0]      recent_q, recent_d;
  logic             in_frame_q, in_frame_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       xor_q, xor_d;
  logic             match_q, match_d;
  logic [ASM_W-1:0] asm_q, asm_d;

  logic [POS_W-1:0] off;
  logic [3:0]       grp;

  assign off = pos_q - TS_POS;
  assign grp = off[5:2];

  always_comb begin
    recent_d   = recent_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    xor_d      = xor_q;
    match_d    = match_q;
    asm_d      = asm_q;
    wr_o       = '0;
    commit_o   = '0;

    if (step_i) begin
      if (!in_frame_q) begin
        if (recent_q == {HDR_BYTE, HDR_BYTE} && byte_i == HDR_KIND) begin
          in_frame_d = 1'b1;
          pos_d      = TEMP_POS;
          xor_d      = HDR_BYTE ^ HDR_BYTE ^ HDR_KIND;
          match_d    = 1'b0;
          asm_d      = '0;
          recent_d   = '0;
        end else begin
          recent_d = {recent_q[7:0], byte_i};
        end
      end else begin
        if (pos_q < CHECK_POS) begin
          xor_d = xor_q ^ byte_i;
        end

        if (pos_q == TEMP_POS) begin
          wr_o.en   = 1'b1;
          wr_o.idx  = WORD_TEMP;
          wr_o.data = {{24{byte_i[7]}}, byte_i};
        end else if (pos_q >= TS_POS && pos_q < CHECK_POS) begin
          case (off[1:0])
            2'd0:    asm_d = {16'h0000, byte_i};
            2'd1:    asm_d[15:8] = byte_i;
            2'd2:    asm_d[23:16] = byte_i;
            default: begin
              wr_o.en   = 1'b1;
              wr_o.idx  = (grp == 4'd0) ? WORD_TS : float_to_index(grp - 4'd1);
              wr_o.data = {byte_i, asm_q};
            end
          endcase
        end else if (pos_q == CHECK_POS) begin
          match_d = (xor_q == byte_i);
        end

        if (pos_q >= LAST_POS) begin
          commit_o.valid = 1'b1;
          commit_o.ok    = match_q;
          in_frame_d     = 1'b0;
          pos_d          = '0;
          recent_d       = '0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q   <= '0;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      xor_q      <= '0;
      match_q    <= 1'b0;
      asm_q      <= '0;
    end else begin
      recent_q   <= recent_d;
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      match_q    <= match_d;
      asm_q      <= asm_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_o.valid |-> in_frame_q && pos_q == LAST_POS)
    else $error("frame completion outside the last frame byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> in_frame_q && pos_q >= TEMP_POS && pos_q < CHECK_POS)
    else $error("record word written outside the frame body");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> pos_q >= TEMP_POS && pos_q < FRAME_LEN)
    else $error("frame position out of range");

endmodule

@@ src/ifpr_reader.sv @@
// ----------------------------------------------------------------------------
// ifpr_reader: record read sequencer and result register
// Walks the 17 words of the oldest slot and owns the output register.
// ----------------------------------------------------------------------------
module ifpr_reader (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  ifpr_pkg::commit_t           commit_i,
  input  logic [ifpr_pkg::SLOT_W-1:0] write_slot_i,
  input  logic [31:0]                 rdata_i,
  input  logic                        out_ready_i,
  output logic                        re_o,
  output logic [ifpr_pkg::ADDR_W-1:0] raddr_o,
  output logic                        idle_o,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  output logic [1:0]                  out_kind_o,
  output logic [ifpr_pkg::IDX_W-1:0]  out_index_o,
  output logic [31:0]                 out_value_o,
  output logic                        out_ok_o,
  output logic                        out_last_o
);
  import ifpr_pkg::*;

  rd_state_e        state_q, state_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;

  logic             ov_q, ov_d;
  kind_e            kind_q, kind_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      val_q, val_d;
  logic             ok_q, ok_d;
  logic             last_q, last_d;

  logic empty;
  logic land;

  assign empty      = (rslot_q == write_slot_i);
  assign out_free_o = !ov_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      RD_IDLE:  if (start_i && !empty) state_d = RD_ISSUE;
      RD_ISSUE: if (out_free_o) state_d = RD_WAIT;
      RD_WAIT:  state_d = (cnt_q == WORD_LAST) ? RD_IDLE : RD_ISSUE;
      default:  state_d = RD_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    re_o    = 1'b0;
    raddr_o = rec_addr(rslot_q, cnt_q);
    idle_o  = (state_q == RD_IDLE);
    land    = 1'b0;
    rslot_d = rslot_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    kind_d  = kind_q;
    idx_d   = idx_q;
    val_d   = val_q;
    ok_d    = ok_q;
    last_d  = last_q;

    case (state_q)
      RD_IDLE: begin
        cnt_d = '0;
        if (start_i && empty) begin
          ov_d   = 1'b1;
          kind_d = KIND_EMPTY;
          idx_d  = '0;
          val_d  = '0;
          ok_d   = 1'b0;
          last_d = 1'b1;
        end
      end
      RD_ISSUE: re_o = out_free_o;
      RD_WAIT: begin
        land   = 1'b1;
        ov_d   = 1'b1;
        kind_d = KIND_WORD;
        idx_d  = cnt_q;
        val_d  = rdata_i;
        ok_d   = 1'b0;
        last_d = (cnt_q == WORD_LAST);
        if (cnt_q == WORD_LAST) begin
          rslot_d = next_slot(rslot_q);
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      default: ;
    endcase

    if (commit_i.valid) begin
      ov_d   = 1'b1;
      kind_d = KIND_STORED;
      idx_d  = '0;
      val_d  = '0;
      ok_d   = commit_i.ok;
      last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RD_IDLE;
      rslot_q <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rslot_q <= rslot_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    ok_q   <= ok_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = kind_q;
  assign out_index_o = idx_q;
  assign out_value_o = val_q;
  assign out_ok_o    = ok_q;
  assign out_last_o  = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (land || commit_i.valid || (start_i && empty && idle_o)) |-> out_free_o)
    else $error("result register overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |=> state_q == RD_WAIT)
    else $error("read data returned with no slot to land in");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_o |-> !empty && !commit_i.valid)
    else $error("ring pointers moved during a record read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    land && cnt_q == WORD_LAST |=> rslot_q == next_slot($past(rslot_q)))
    else $error("read slot not advanced after the final word");

endmodule

@@ src/imu_frame_parser_ring_unit.sv @@
// ----------------------------------------------------------------------------
// imu_frame_parser_ring_unit: serial IMU frame parser with a record ring
// Hunts for 7E 7E 0C, parses 70-byte frames into 17-word records stored
// in a ring memory, and replays the oldest record on request.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                          handshake
//  item_i    in   op, data_byte                                    valid/ready
//  result_o  out  kind, word_index, word_value, checksum_ok, last  valid/ready
//
//  A received byte is taken whenever no record read runs
//  and the result register is free or drains in the same cycle.
//  A record read walks the 17 words of the oldest record, each issued and then
//  landed through the RAM's registered read port; an issue waits while
//  result_o stalls. An empty ring answers with a single empty result.
//  Reset clears the parser and ring pointers; the record store has no reset,
//  no slot is read before a full frame has been written to it.
//
module imu_frame_parser_ring_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ifpr_in_if.sink      item_i,
  ifpr_out_if.source   result_o
);
  import ifpr_pkg::*;

  logic              accept;
  logic              byte_step;
  logic              read_start;

  wr_req_t           wr;
  commit_t           commit;

  logic [SLOT_W-1:0] wslot_q, wslot_d;

  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       rdata;
  logic              rd_idle;
  logic              out_free;

  // Take a new transaction only between record reads, with room for a result.
  assign item_i.ready = rd_idle && out_free;
  assign accept       = item_i.valid && item_i.ready;
  assign byte_step    = accept && (item_i.op == OP_BYTE);
  assign read_start   = accept && (item_i.op == OP_READ);

  ifpr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (byte_step),
    .byte_i   (item_i.data_byte),
    .wr_o     (wr),
    .commit_o (commit)
  );

  // Advance the write slot on every finished frame, checked or not; an
  // overrun past the read slot silently drops the unread records.
  assign wslot_d = commit.valid ? next_slot(wslot_q) : wslot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
    end else begin
      wslot_q <= wslot_d;
    end
  end

  // Record store: the write slot is never the read slot of a non-empty ring,
  // and reads never overlap byte writes, so no forwarding path is needed.
  ifpr_ram #(
    .WIDTH (32),
    .DEPTH (RING_DEPTH * REC_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (rec_addr(wslot_q, wr.idx)),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ifpr_reader u_reader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (read_start),
    .commit_i     (commit),
    .write_slot_i (wslot_q),
    .rdata_i      (rdata),
    .out_ready_i  (result_o.ready),
    .re_o         (re),
    .raddr_o      (raddr),
    .idle_o       (rd_idle),
    .out_free_o   (out_free),
    .out_valid_o  (result_o.valid),
    .out_kind_o   (result_o.kind),
    .out_index_o  (result_o.word_index),
    .out_value_o  (result_o.word_value),
    .out_ok_o     (result_o.checksum_ok),
    .out_last_o   (result_o.last)
  );

endmodule
